FILE: design/mm_pkg.sv
// Shared types, constants and helpers for the matrix multiplier.
`default_nettype none
package mm_pkg;

  localparam int DIM     = 8;                 // matrix edge, one cell per column
  localparam int IDX_W   = $clog2(DIM);       // row / column index width
  localparam int DIM_W   = $clog2(DIM + 1);   // width holding 1..DIM
  localparam int EW      = 16;                // element width, Q8.8
  localparam int PROD_W  = 2 * EW;            // one product term, Q16.16
  localparam int ACC_W   = 40;                // full-width sum, Q24.16
  localparam int A_AW    = 2 * IDX_W;         // A store address
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  // element of A flowing down the cell chain
  typedef struct packed {
    logic                  vld;
    logic                  first;   // k == 0, restarts the sum
    logic [IDX_W-1:0]      k;
    logic signed [EW-1:0]  a;
  } token_t;

  // B element write, broadcast to all cells
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      row;
    logic [IDX_W-1:0]      col;
    logic signed [EW-1:0]  val;
  } bwr_t;

  // 0 reads as 1, anything above DIM reads as DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [3:0] v);
    logic [DIM_W-1:0] r;
    if (v == 4'd0) begin
      r = DIM_W'(1);
    end else if (v > 4'(DIM)) begin
      r = DIM_W'(DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/mm_cell.sv
// One column cell: holds a column of B, multiplies and accumulates one product element.
`default_nettype none
module mm_cell (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [mm_pkg::IDX_W-1:0]        col_id,
  input  wire mm_pkg::bwr_t                    bwr,
  input  wire mm_pkg::token_t                  tok_in,
  output mm_pkg::token_t                       tok_out,
  input  wire logic                            shift,
  input  wire logic signed [mm_pkg::ACC_W-1:0] acc_in,
  output logic signed [mm_pkg::ACC_W-1:0]      acc_out
);

  logic signed [mm_pkg::EW-1:0]     b_mem [mm_pkg::DIM];
  logic signed [mm_pkg::EW-1:0]     b_q_r;
  mm_pkg::token_t                   tok_r;
  logic signed [mm_pkg::PROD_W-1:0] prod_r;
  logic                             pv_r;
  logic                             pf_r;
  logic signed [mm_pkg::ACC_W-1:0]  acc_r;
  logic signed [mm_pkg::ACC_W-1:0]  prod_ext;

  // column store, registered read at the token's k
  always_ff @(posedge clk) begin
    if (bwr.we && bwr.col == col_id) begin
      b_mem[bwr.row] <= bwr.val;
    end
    b_q_r <= b_mem[tok_in.k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      pv_r  <= 1'b0;
      pf_r  <= 1'b0;
    end else begin
      tok_r <= tok_in;
      pv_r  <= tok_r.vld;
      pf_r  <= tok_r.first;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= tok_r.a * b_q_r;
  end

  assign prod_ext = {{(mm_pkg::ACC_W - mm_pkg::PROD_W){prod_r[mm_pkg::PROD_W-1]}}, prod_r};

  // unload shifts toward cell 0; never overlaps accumulation
  always_ff @(posedge clk) begin
    if (shift) begin
      acc_r <= acc_in;
    end else if (pv_r) begin
      acc_r <= pf_r ? prod_ext : acc_r + prod_ext;
    end
  end

  assign tok_out = tok_r;
  assign acc_out = acc_r;

endmodule
`default_nettype wire

FILE: design/mm_seq.sv
// Sequencer: A store, row feed into the cell chain, result unload and output register.
`default_nettype none
module mm_seq (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [mm_pkg::OP_W-1:0]         opcode,
  input  wire logic [mm_pkg::IDX_W-1:0]        row_index,
  input  wire logic [mm_pkg::IDX_W-1:0]        col_index,
  input  wire logic signed [mm_pkg::EW-1:0]    element_value,
  input  wire logic [mm_pkg::DIM_W-1:0]        ar,
  input  wire logic [mm_pkg::DIM_W-1:0]        ac,
  input  wire logic [mm_pkg::DIM_W-1:0]        br,
  input  wire logic [mm_pkg::DIM_W-1:0]        bc,
  output mm_pkg::bwr_t                         bwr,
  output mm_pkg::token_t                       tok,
  output logic                                 shift,
  input  wire logic signed [mm_pkg::ACC_W-1:0] acc0,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [mm_pkg::IDX_W-1:0]             out_row,
  output logic [mm_pkg::IDX_W-1:0]             out_col,
  output logic signed [mm_pkg::ACC_W-1:0]      product_value,
  output logic                                 out_last,
  output logic                                 size_error
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FEED   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_UNLOAD = 3'd3;
  localparam logic [2:0] ST_ERR    = 3'd4;

  // wait after the feed ends, so that the far cell's sum is final before the first shift
  localparam int DRAIN_LEN = mm_pkg::DIM + 3;
  localparam int DRAIN_W   = $clog2(DRAIN_LEN);

  logic [2:0]                      st_r, st_nxt;
  logic [mm_pkg::IDX_W-1:0]        i_r, i_nxt;
  logic [mm_pkg::IDX_W-1:0]        k_r, k_nxt;
  logic [mm_pkg::IDX_W-1:0]        j_r, j_nxt;
  logic [DRAIN_W-1:0]              cnt_r, cnt_nxt;
  logic                            fv_r;
  logic [mm_pkg::IDX_W-1:0]        fk_r;
  logic signed [mm_pkg::EW-1:0]    a_mem [2**mm_pkg::A_AW];
  logic signed [mm_pkg::EW-1:0]    a_q_r;
  logic                            acc_in;
  logic                            a_we;
  logic                            slot_free;
  logic                            emit, emit_err;
  logic                            row_end, col_end, k_end;
  logic                            out_v_r;
  logic [mm_pkg::IDX_W-1:0]        out_row_r, out_col_r;
  logic signed [mm_pkg::ACC_W-1:0] out_val_r;
  logic                            out_last_r, out_err_r;

  assign in_ready  = (st_r == ST_IDLE);
  assign acc_in    = in_valid && in_ready;
  assign a_we      = acc_in && opcode == mm_pkg::OP_LOAD_A;
  assign slot_free = !out_v_r || out_ready;
  assign k_end     = ({1'b0, k_r} == ac - mm_pkg::DIM_W'(1));
  assign row_end   = ({1'b0, i_r} == ar - mm_pkg::DIM_W'(1));
  assign col_end   = ({1'b0, j_r} == bc - mm_pkg::DIM_W'(1));

  assign bwr.we  = acc_in && opcode == mm_pkg::OP_LOAD_B;
  assign bwr.row = row_index;
  assign bwr.col = col_index;
  assign bwr.val = element_value;

  // A store, row-major
  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[{row_index, col_index}] <= element_value;
    end
    a_q_r <= a_mem[{i_r, k_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= (st_r == ST_FEED);
    end
    fk_r <= k_r;
  end

  assign tok.vld   = fv_r;
  assign tok.first = (fk_r == '0);
  assign tok.k     = fk_r;
  assign tok.a     = a_q_r;

  always_comb begin
    st_nxt   = st_r;
    i_nxt    = i_r;
    k_nxt    = k_r;
    j_nxt    = j_r;
    cnt_nxt  = cnt_r;
    emit     = 1'b0;
    emit_err = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (acc_in && opcode == mm_pkg::OP_COMPUTE) begin
          i_nxt = '0;
          k_nxt = '0;
          st_nxt = (ac != br) ? ST_ERR : ST_FEED;
        end
      end
      ST_FEED: begin
        if (k_end) begin
          cnt_nxt = '0;
          st_nxt  = ST_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (cnt_r == DRAIN_W'(DRAIN_LEN - 1)) begin
          j_nxt  = '0;
          st_nxt = ST_UNLOAD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_UNLOAD: begin
        if (slot_free) begin
          emit = 1'b1;
          if (col_end) begin
            if (row_end) begin
              st_nxt = ST_IDLE;
            end else begin
              i_nxt  = i_r + 1'b1;
              k_nxt  = '0;
              st_nxt = ST_FEED;
            end
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          emit_err = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign shift = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      i_r   <= '0;
      k_r   <= '0;
      j_r   <= '0;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      i_r   <= i_nxt;
      k_r   <= k_nxt;
      j_r   <= j_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit || emit_err) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row_r  <= i_r;
      out_col_r  <= j_r;
      out_val_r  <= acc0;
      out_last_r <= row_end && col_end;
      out_err_r  <= 1'b0;
    end else if (emit_err) begin
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_val_r  <= '0;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end
  end

  assign out_valid     = out_v_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign product_value = out_val_r;
  assign out_last      = out_last_r;
  assign size_error    = out_err_r;

endmodule
`default_nettype wire

FILE: design/matrix_multiply.sv
// Top level of the matrix multiplier: config registers, sequencer and the cell chain.
`default_nettype none
// Multiplies A (a_rows x a_cols) by B (b_rows x b_cols), signed Q8.8 elements, exact
// Q24.16 sums. Each input transaction carries an opcode in in_tuser: load A element,
// load B element, or compute. A compute streams every product element in row-major
// order on the out_ channel, out_tlast on the final one; if the clamped a_cols differs
// from the clamped b_rows it gives one transaction instead with out_tuser (size error)
// set, zero data and out_tlast. Register values of 0 act as 1 and values above 8 act
// as 8. The datapath is a chain of 8 column cells, each holding one column of B: a row
// of A walks down the chain one element per cycle while every cell accumulates its
// product element, then the sums shift out through cell 0. Per row of the result a
// compute feeds a_cols elements of A, waits for the far cell's sum to be final, and
// unloads b_cols sums, held back while out_tready stalls; in_tready is low until the
// compute ends. The stores have no reset: elements must be loaded before they are used
// by a compute.
module matrix_multiply (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // row_index[2:0], col_index[5:3], element_value[21:6]
  input  wire logic [1:0]  in_tuser,   // opcode[1:0]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // out_row[2:0], out_col[5:3], product_value[45:6]
  output logic             out_tlast,  // last
  output logic             out_tuser,  // size_error
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [3:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic       cfg_wr;

  logic [mm_pkg::DIM_W-1:0] ar, ac, br, bc;

  mm_pkg::bwr_t                    bwr;
  mm_pkg::token_t                  tok_c [mm_pkg::DIM];
  logic signed [mm_pkg::ACC_W-1:0] acc_c [mm_pkg::DIM];
  logic                            shift;

  logic [mm_pkg::IDX_W-1:0]        res_row, res_col;
  logic signed [mm_pkg::ACC_W-1:0] res_val;

  // APB register file; pready tied high, one write per access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= 4'd8;
      a_cols_r <= 4'd8;
      b_rows_r <= 4'd8;
      b_cols_r <= 4'd8;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        mm_pkg::REG_A_ROWS: a_rows_r <= cfg_pwdata[3:0];
        mm_pkg::REG_A_COLS: a_cols_r <= cfg_pwdata[3:0];
        mm_pkg::REG_B_ROWS: b_rows_r <= cfg_pwdata[3:0];
        mm_pkg::REG_B_COLS: b_cols_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      mm_pkg::REG_A_ROWS: cfg_prdata = {28'd0, a_rows_r};
      mm_pkg::REG_A_COLS: cfg_prdata = {28'd0, a_cols_r};
      mm_pkg::REG_B_ROWS: cfg_prdata = {28'd0, b_rows_r};
      mm_pkg::REG_B_COLS: cfg_prdata = {28'd0, b_cols_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // effective dimensions used by every check and loop
  assign ar = mm_pkg::clamp_dim(a_rows_r);
  assign ac = mm_pkg::clamp_dim(a_cols_r);
  assign br = mm_pkg::clamp_dim(b_rows_r);
  assign bc = mm_pkg::clamp_dim(b_cols_r);

  mm_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .opcode        (in_tuser),
    .row_index     (in_tdata[2:0]),
    .col_index     (in_tdata[5:3]),
    .element_value (in_tdata[21:6]),
    .ar            (ar),
    .ac            (ac),
    .br            (br),
    .bc            (bc),
    .bwr           (bwr),
    .tok           (tok_c[0]),
    .shift         (shift),
    .acc0          (acc_c[0]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_row       (res_row),
    .out_col       (res_col),
    .product_value (res_val),
    .out_last      (out_tlast),
    .size_error    (out_tuser)
  );

  // cell g owns column g of B; tokens move up the chain, sums shift down to cell 0
  for (genvar g = 0; g < mm_pkg::DIM; g++) begin : g_cell
    if (g < mm_pkg::DIM - 1) begin : g_mid
      mm_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .col_id  (mm_pkg::IDX_W'(g)),
        .bwr     (bwr),
        .tok_in  (tok_c[g]),
        .tok_out (tok_c[g+1]),
        .shift   (shift),
        .acc_in  (acc_c[g+1]),
        .acc_out (acc_c[g])
      );
    end else begin : g_end
      mm_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .col_id  (mm_pkg::IDX_W'(g)),
        .bwr     (bwr),
        .tok_in  (tok_c[g]),
        .tok_out (),
        .shift   (shift),
        .acc_in  ({mm_pkg::ACC_W{1'b0}}),
        .acc_out (acc_c[g])
      );
    end
  end

  assign out_tdata = {2'b00, res_val, res_col, res_row};

endmodule
`default_nettype wire

FILE: design/mm_chk.sv
// Port-level checker for the matrix multiplier, bound to the top level.
`default_nettype none
module mm_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  // size error: single zero result marked last
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == '0)
    else $error("size error result malformed");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind matrix_multiply mm_chk u_mm_chk (.*);
`default_nettype wire
